// ----- hw/rtl/grs_pkg.sv -----
// grs_pkg: shared types and constants of the graph reachable set unit
// item structs, adjacency store control, register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

  localparam int NODE_W        = 6;
  localparam int COUNT_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int MAX_NODES_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 2'd1;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
  localparam logic [NODE_W-1:0]  START_NODE_RESET = 6'd0;

  typedef struct packed {
    logic [NODE_W-1:0] edge_a;
    logic [NODE_W-1:0] edge_b;
    logic              edge_valid;
    logic              last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last_node;
    logic              bad_start;
  } result_item_t;

  typedef struct packed {
    logic              wr;
    logic              clear;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] rd_addr;
  } adj_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grs_adj_store.sv -----
// grs_adj_store: adjacency store, two single-write memories holding row a and row b
// of every edge, with per-row valid bits so that a clear empties all rows at once
// depends on grs_pkg
`timescale 1ns / 1ps
`default_nettype none

module grs_adj_store #(
  parameter int MAX_NODES = grs_pkg::MAX_NODES_DEF,
  parameter int NW        = $clog2(MAX_NODES)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire grs_pkg::adj_ctl_t    ctl,
  output logic [MAX_NODES-1:0]      row
);

  logic [MAX_NODES-1:0] mem_fwd [MAX_NODES];
  logic [MAX_NODES-1:0] mem_rev [MAX_NODES];
  logic [MAX_NODES-1:0] vld_fwd;
  logic [MAX_NODES-1:0] vld_rev;
  logic [MAX_NODES-1:0] rd_fwd;
  logic [MAX_NODES-1:0] rd_rev;
  logic                 rdv_fwd;
  logic                 rdv_rev;
  logic [NW-1:0]        addr_a;
  logic [NW-1:0]        addr_b;
  logic [NW-1:0]        addr_rd;
  logic [MAX_NODES-1:0] one_a;
  logic [MAX_NODES-1:0] one_b;

  assign addr_a  = ctl.a[NW-1:0];
  assign addr_b  = ctl.b[NW-1:0];
  assign addr_rd = ctl.rd_addr[NW-1:0];
  assign one_a   = MAX_NODES'(1) << addr_a;
  assign one_b   = MAX_NODES'(1) << addr_b;

  // row a gets bit b
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      if (vld_fwd[addr_a]) begin
        mem_fwd[addr_a][addr_b] <= 1'b1;
      end else begin
        mem_fwd[addr_a] <= one_b;
      end
    end
    rd_fwd <= mem_fwd[addr_rd];
  end

  // row b gets bit a
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      if (vld_rev[addr_b]) begin
        mem_rev[addr_b][addr_a] <= 1'b1;
      end else begin
        mem_rev[addr_b] <= one_a;
      end
    end
    rd_rev <= mem_rev[addr_rd];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld_fwd <= '0;
      vld_rev <= '0;
      rdv_fwd <= 1'b0;
      rdv_rev <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld_fwd[addr_a] <= 1'b1;
        vld_rev[addr_b] <= 1'b1;
      end
      rdv_fwd <= vld_fwd[addr_rd];
      rdv_rev <= vld_rev[addr_rd];
    end
  end

  assign row = (rd_fwd & {MAX_NODES{rdv_fwd}}) | (rd_rev & {MAX_NODES{rdv_rev}});

endmodule

`default_nettype wire

// ----- hw/rtl/grs_stack.sv -----
// grs_stack: pending node stack, one write and one registered read per cycle
// depends on grs_pkg for the default depth
`timescale 1ns / 1ps
`default_nettype none

module grs_stack #(
  parameter int MAX_NODES = grs_pkg::MAX_NODES_DEF,
  parameter int NW        = $clog2(MAX_NODES)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [NW-1:0] waddr,
  input  wire logic [NW-1:0] wdata,
  input  wire logic [NW-1:0] raddr,
  output logic [NW-1:0]      rdata
);

  logic [NW-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/graph_reachable_set_unit.sv -----
// graph_reachable_set_unit: top level, edge loading, depth-first walk sequencer,
// ascending result scan and output register
// depends on grs_pkg, grs_adj_store, grs_stack
//
//  channel | handshake            | payload                 | role
//  link    | link_valid/stall     | grs_pkg::edge_item_t    | edges in, one per cycle when not stalled
//  reach   | reach_valid/stall    | grs_pkg::result_item_t  | reachable nodes out
//  cfg     | cfg_valid/ready      | cfg_index, cfg_data     | node_count, start_node
//
// loading accepts an edge whenever link_stall is low; link_stall is high from the last edge until the run ends
// walk: a popped node passes S_POP, S_WSTK, S_WADJ and S_PUSH, which pushes its fresh neighbors
// scan: steps through the indices in ascending order up to the highest reachable node, waiting on output stalls
// reset clears control state and the adjacency row valid bits at once, no clearing pass
// reach_stall holds the output register; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module graph_reachable_set_unit #(
  parameter int MAX_NODES = grs_pkg::MAX_NODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             link_valid,
  output logic                                  link_stall,
  input  wire grs_pkg::edge_item_t              link,
  output logic                                  reach_valid,
  input  wire logic                             reach_stall,
  output grs_pkg::result_item_t                 reach,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [grs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [grs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = $clog2(MAX_NODES + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FAULT = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_WSTK  = 3'd3;
  localparam logic [2:0] S_WADJ  = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [grs_pkg::COUNT_W-1:0]   node_count;
  logic [grs_pkg::NODE_W-1:0]    start_node;
  logic [grs_pkg::COUNT_W-1:0]   eff;
  logic [MAX_NODES-1:0]          range;
  logic [MAX_NODES-1:0]          visited;
  logic [MAX_NODES-1:0]          fresh;
  logic [MAX_NODES-1:0]          row;
  logic [MAX_NODES-1:0]          left;
  logic [LW-1:0]                 level;
  logic [LW-1:0]                 lvl_dec;
  logic [NW-1:0]                 scan;
  logic [NW-1:0]                 pick;
  logic [NW-1:0]                 stk_rdata;
  logic                          stk_we;
  logic [NW-1:0]                 stk_waddr;
  logic [NW-1:0]                 stk_wdata;
  logic                          accept;
  logic                          edge_ok;
  logic                          start_bad;
  logic                          out_free;
  logic                          out_load;
  grs_pkg::result_item_t         out_data;
  grs_pkg::adj_ctl_t             adj_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= grs_pkg::NODE_COUNT_RESET;
      start_node <= grs_pkg::START_NODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        grs_pkg::CFG_NODE_COUNT: node_count <= cfg_data;
        grs_pkg::CFG_START_NODE: start_node <= cfg_data[grs_pkg::NODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff = (node_count > grs_pkg::COUNT_W'(MAX_NODES)) ?
               grs_pkg::COUNT_W'(MAX_NODES) : node_count;

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      range[k] = grs_pkg::COUNT_W'(k) < eff;
    end
  end

  assign link_stall = (state != S_LOAD);
  assign accept     = link_valid && !link_stall;
  assign edge_ok    = link.edge_valid &&
                      ({1'b0, link.edge_a} < eff) && ({1'b0, link.edge_b} < eff);
  assign start_bad  = {1'b0, start_node} >= eff;
  assign lvl_dec    = level - LW'(1);
  assign out_free   = !reach_valid || !reach_stall;

  // lowest pending neighbor
  always_comb begin
    pick = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        pick = NW'(i);
      end
    end
  end

  assign left = visited & ~(MAX_NODES'(1) << scan);

  always_comb begin
    adj_ctl.wr      = accept && edge_ok;
    adj_ctl.clear   = 1'b0;
    adj_ctl.a       = link.edge_a;
    adj_ctl.b       = link.edge_b;
    adj_ctl.rd_addr = grs_pkg::NODE_W'(stk_rdata);
    stk_we          = 1'b0;
    stk_waddr       = level[NW-1:0];
    stk_wdata       = pick;
    out_load        = 1'b0;
    out_data.node      = grs_pkg::NODE_W'(scan);
    out_data.last_node = 1'b0;
    out_data.bad_start = 1'b0;
    state_next      = state;
    unique case (state)
      S_LOAD: begin
        if (accept && link.last_edge) begin
          if (start_bad) begin
            state_next = S_FAULT;
          end else begin
            stk_we     = 1'b1;
            stk_waddr  = '0;
            stk_wdata  = start_node[NW-1:0];
            state_next = S_POP;
          end
        end
      end
      S_FAULT: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_data.node      = '0;
          out_data.last_node = 1'b1;
          out_data.bad_start = 1'b1;
          adj_ctl.clear      = 1'b1;
          state_next         = S_LOAD;
        end
      end
      S_POP: begin
        state_next = (level == '0) ? S_EMIT : S_WSTK;
      end
      S_WSTK: begin
        state_next = S_WADJ;
      end
      S_WADJ: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (fresh == '0) begin
          state_next = S_POP;
        end else begin
          stk_we = 1'b1;
        end
      end
      S_EMIT: begin
        if (visited[scan] && out_free) begin
          out_load           = 1'b1;
          out_data.last_node = (left == '0);
          if (left == '0) begin
            adj_ctl.clear = 1'b1;
            state_next    = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      level   <= '0;
      visited <= '0;
      scan    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_LOAD: begin
          if (accept && link.last_edge && !start_bad) begin
            visited <= MAX_NODES'(1) << start_node[NW-1:0];
            level   <= LW'(1);
          end
        end
        S_FAULT: begin
          if (out_free) begin
            visited <= '0;
            level   <= '0;
          end
        end
        S_POP: begin
          scan <= '0;
          if (level != '0) begin
            level <= lvl_dec;
          end
        end
        S_WADJ: begin
          visited <= visited | (row & range & ~visited);
        end
        S_PUSH: begin
          if (fresh != '0) begin
            level <= level + LW'(1);
          end
        end
        S_EMIT: begin
          if (!visited[scan]) begin
            scan <= scan + NW'(1);
          end else if (out_free) begin
            visited <= left;
            scan    <= scan + NW'(1);
            if (left == '0) begin
              level <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WADJ) begin
      fresh <= row & range & ~visited;
    end else if (state == S_PUSH && fresh != '0) begin
      fresh <= fresh & ~(MAX_NODES'(1) << pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_valid <= 1'b0;
    end else if (out_load) begin
      reach_valid <= 1'b1;
    end else if (!reach_stall) begin
      reach_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reach <= out_data;
    end
  end

  grs_adj_store #(
    .MAX_NODES (MAX_NODES),
    .NW        (NW)
  ) u_adj (
    .clk (clk),
    .rst (rst),
    .ctl (adj_ctl),
    .row (row)
  );

  grs_stack #(
    .MAX_NODES (MAX_NODES),
    .NW        (NW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (lvl_dec[NW-1:0]),
    .rdata (stk_rdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/grs_checker.sv -----
// grs_checker: port-level assertions for graph_reachable_set_unit, bound to the top level
// depends on grs_pkg
`timescale 1ns / 1ps
`default_nettype none

module grs_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             link_valid,
  input  wire logic                             link_stall,
  input  wire grs_pkg::edge_item_t              link,
  input  wire logic                             reach_valid,
  input  wire logic                             reach_stall,
  input  wire grs_pkg::result_item_t            reach
);

  logic                       in_run;
  logic [grs_pkg::NODE_W-1:0] prev;

  // track the previous node of the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
      prev   <= '0;
    end else if (reach_valid && !reach_stall) begin
      in_run <= !reach.last_node;
      prev   <= reach.node;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    reach_valid && reach_stall |=> reach_valid && $stable(reach))
    else $error("result item changed while stalled");

  a_fault_form: assert property (@(posedge clk) disable iff (rst)
    reach_valid && reach.bad_start |-> reach.last_node && reach.node == '0)
    else $error("fault item is not a single marked zero node");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    reach_valid && in_run |-> reach.node > prev && !reach.bad_start)
    else $error("result nodes not ascending");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    link_valid && !link_stall && link.last_edge |=> link_stall)
    else $error("input taken right after the last edge");

endmodule

bind graph_reachable_set_unit grs_checker u_grs_checker (.*);

`default_nettype wire
